### src/bpa_pkg.sv
// Shared types for the buddy page allocator.
// No dependencies; used by the memory, top level and testbench.
package bpa_pkg;

  // One page entry of the block-head table
  typedef struct packed {
    logic       valid;
    logic       free;
    logic [3:0] order;
  } bpa_entry_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } bpa_action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_MEM    = 2'd1,
    ST_BAD_ORDER = 2'd2,
    ST_BAD_FREE  = 2'd3
  } bpa_status_e;

  typedef enum logic [3:0] {
    FSM_INIT,
    FSM_IDLE,
    FSM_SCAN_RD,
    FSM_SCAN_EV,
    FSM_SPLIT,
    FSM_FREE_EV,
    FSM_MERGE_RD,
    FSM_MERGE_EV,
    FSM_FIN,
    FSM_DONE
  } bpa_fsm_e;

endpackage

### src/bpa_req_if.sv
// Request channel of the buddy page allocator.
// Depends on nothing but the payload widths of the work item.
interface bpa_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [3:0]  req_order;
  logic [11:0] page_index;

  modport source (output valid, action, req_order, page_index, input ready);
  modport sink   (input valid, action, req_order, page_index, output ready);
endinterface

### src/bpa_rsp_if.sv
// Response channel of the buddy page allocator.
// Depends on nothing but the payload widths of the result word.
interface bpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [11:0] alloc_page;
  logic [1:0]  status;
  logic [12:0] free_pages;

  modport source (output valid, alloc_page, status, free_pages, input ready);
  modport sink   (input valid, alloc_page, status, free_pages, output ready);
endinterface

### src/bpa_mem.sv
// Block-head table: one entry per page, one write and one read port.
// Depends on bpa_pkg for the entry type. Read data is registered.
module bpa_mem #(
  parameter int AW = 12
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  bpa_pkg::bpa_entry_t wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output bpa_pkg::bpa_entry_t rdata_o
);
  import bpa_pkg::*;

  bpa_entry_t mem_q [2**AW];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### src/buddy_page_allocator_unit.sv
// Buddy page allocator top level: control sequencer around the head table.
// Depends on bpa_pkg, bpa_req_if, bpa_rsp_if and bpa_mem.
//
//  channel | dir | word fields
//  req_i   | in  | action, req_order, page_index
//  rsp_o   | out | alloc_page, status, free_pages
//
// An alloc probes heads serially through the single table read port (pool >>
// req_order heads at most, stops at the first free head of the exact order),
// then splits the found block one level at a time; a free merges upward one
// buddy at a time. After reset a clearing pass writes every table entry; no
// request is taken meanwhile. A new request is taken while a response word
// waits; its own word holds in the done state until the output register frees
// up.
module buddy_page_allocator_unit #(
  parameter int POOL_PAGES_LOG2 = 12,
  parameter int ORDER_CAP       = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  bpa_req_if.sink   req_i,
  bpa_rsp_if.source rsp_o
);
  import bpa_pkg::*;

  localparam int AW   = POOL_PAGES_LOG2;
  localparam int FTW  = POOL_PAGES_LOG2 + 1;
  localparam int TOP  = (ORDER_CAP < POOL_PAGES_LOG2) ? ORDER_CAP : POOL_PAGES_LOG2;
  localparam logic [3:0] TOP4 = 4'(TOP);
  localparam logic [3:0] MAX4 = 4'(ORDER_CAP);

  bpa_fsm_e state_q, state_d;
  logic [AW:0]    scan_q, scan_d;
  logic [AW-1:0]  base_q, base_d;
  logic [3:0]     ord_q, ord_d;
  logic [3:0]     req_q, req_d;
  logic           found_q, found_d;
  logic [FTW-1:0] ftot_q, ftot_d;
  logic [11:0]    res_page_q, res_page_d;
  bpa_status_e    res_st_q, res_st_d;
  logic           ovalid_q, ovalid_d;
  logic [11:0]    opage_q, opage_d;
  logic [1:0]     ost_q, ost_d;
  logic [12:0]    ofree_q, ofree_d;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  bpa_entry_t     mem_wdata, mem_rdata;

  logic [23:0]    in_page_w, base_w;
  logic [AW-1:0]  in_page;
  logic           in_range;
  logic [AW-1:0]  buddy;
  logic [AW:0]    step;
  logic           accept;
  logic           out_free;
  logic           hit;

  bpa_mem #(.AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // helpers
  assign in_page_w = 24'(req_i.page_index);
  assign in_page   = in_page_w[AW-1:0];
  assign in_range  = (in_page_w >> AW) == 24'd0;
  assign base_w    = 24'(base_q);
  assign buddy     = base_q ^ (AW'(1) << ord_q);
  assign step      = (AW+1)'(1) << req_q;
  assign accept    = req_i.valid && req_i.ready;
  assign out_free  = !ovalid_q || rsp_o.ready;
  assign hit       = mem_rdata.valid && mem_rdata.free && (mem_rdata.order >= req_q) &&
                     (mem_rdata.order <= TOP4) && (!found_q || mem_rdata.order < ord_q);

  assign req_i.ready      = (state_q == FSM_IDLE);
  assign rsp_o.valid      = ovalid_q;
  assign rsp_o.alloc_page = opage_q;
  assign rsp_o.status     = ost_q;
  assign rsp_o.free_pages = ofree_q;

  // read address select
  always_comb begin
    unique case (state_q)
      FSM_IDLE:     mem_raddr = in_page;
      FSM_SCAN_RD:  mem_raddr = scan_q[AW-1:0];
      default:      mem_raddr = buddy;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_INIT:     if (scan_q[AW-1:0] == {AW{1'b1}}) state_d = FSM_IDLE;
      FSM_IDLE: begin
        if (accept) begin
          if (req_i.action == ACT_FREE) begin
            state_d = in_range ? FSM_FREE_EV : FSM_DONE;
          end else if (req_i.req_order > MAX4 || req_i.req_order > TOP4) begin
            state_d = FSM_DONE;
          end else begin
            state_d = FSM_SCAN_RD;
          end
        end
      end
      FSM_SCAN_RD:  state_d = FSM_SCAN_EV;
      FSM_SCAN_EV: begin
        if (hit && mem_rdata.order == req_q) state_d = FSM_SPLIT;
        else if ((scan_q + step) > (AW+1)'(2**AW - 1))
          state_d = (found_q || hit) ? FSM_SPLIT : FSM_DONE;
        else state_d = FSM_SCAN_RD;
      end
      FSM_SPLIT:    if (ord_q == req_q) state_d = FSM_DONE;
      FSM_FREE_EV: begin
        if (!mem_rdata.valid || mem_rdata.free) state_d = FSM_DONE;
        else if (mem_rdata.order >= TOP4) state_d = FSM_FIN;
        else state_d = FSM_MERGE_RD;
      end
      FSM_MERGE_RD: state_d = FSM_MERGE_EV;
      FSM_MERGE_EV: begin
        if (mem_rdata.valid && mem_rdata.free && mem_rdata.order == ord_q &&
            (ord_q + 4'd1) < TOP4) state_d = FSM_MERGE_RD;
        else state_d = FSM_FIN;
      end
      FSM_FIN:      state_d = FSM_DONE;
      FSM_DONE:     if (out_free) state_d = FSM_IDLE;
      default:      state_d = FSM_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    scan_d     = scan_q;
    base_d     = base_q;
    ord_d      = ord_q;
    req_d      = req_q;
    found_d    = found_q;
    ftot_d     = ftot_q;
    res_page_d = res_page_q;
    res_st_d   = res_st_q;
    ovalid_d   = ovalid_q && !rsp_o.ready;
    opage_d    = opage_q;
    ost_d      = ost_q;
    ofree_d    = ofree_q;
    mem_we     = 1'b0;
    mem_waddr  = base_q;
    mem_wdata  = '{valid: 1'b0, free: 1'b0, order: TOP4};
    unique case (state_q)
      FSM_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = scan_q[AW-1:0];
        mem_wdata.valid = ((scan_q[AW-1:0] & AW'((2**TOP) - 1)) == '0);
        mem_wdata.free  = mem_wdata.valid;
        scan_d = scan_q + (AW+1)'(1);
      end
      FSM_IDLE: begin
        res_page_d = 12'd0;
        req_d      = req_i.req_order;
        base_d     = in_page;
        scan_d     = '0;
        found_d    = 1'b0;
        if (req_i.action == ACT_FREE) res_st_d = ST_BAD_FREE;
        else if (req_i.req_order > MAX4) res_st_d = ST_BAD_ORDER;
        else res_st_d = ST_NO_MEM;
      end
      FSM_SCAN_EV: begin
        if (hit) begin
          found_d = 1'b1;
          base_d  = scan_q[AW-1:0];
          ord_d   = mem_rdata.order;
        end
        scan_d = scan_q + step;
      end
      FSM_SPLIT: begin
        mem_we = 1'b1;
        if (ord_q != req_q) begin
          mem_waddr = base_q + (AW'(1) << (ord_q - 4'd1));
          mem_wdata = '{valid: 1'b1, free: 1'b1, order: ord_q - 4'd1};
          ord_d     = ord_q - 4'd1;
        end else begin
          mem_wdata  = '{valid: 1'b1, free: 1'b0, order: req_q};
          ftot_d     = ftot_q - (FTW'(1) << req_q);
          res_page_d = base_w[11:0];
          res_st_d   = ST_OK;
        end
      end
      FSM_FREE_EV: begin
        if (mem_rdata.valid && !mem_rdata.free) begin
          ord_d    = (mem_rdata.order > TOP4) ? TOP4 : mem_rdata.order;
          ftot_d   = ftot_q + (FTW'(1) << ((mem_rdata.order > TOP4) ? TOP4 : mem_rdata.order));
          res_st_d = ST_OK;
        end
      end
      FSM_MERGE_EV: begin
        if (mem_rdata.valid && mem_rdata.free && mem_rdata.order == ord_q) begin
          mem_we    = 1'b1;
          mem_waddr = base_q | (AW'(1) << ord_q);
          mem_wdata = '{valid: 1'b0, free: 1'b0, order: mem_rdata.order};
          base_d    = base_q & ~(AW'(1) << ord_q);
          ord_d     = ord_q + 4'd1;
        end
      end
      FSM_FIN: begin
        mem_we    = 1'b1;
        mem_wdata = '{valid: 1'b1, free: 1'b1, order: ord_q};
      end
      FSM_DONE: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          opage_d  = res_page_q;
          ost_d    = res_st_q;
          ofree_d  = 13'(ftot_q);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_INIT;
      scan_q   <= '0;
      ftot_q   <= FTW'(2**AW);
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      scan_q   <= scan_d;
      ftot_q   <= ftot_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    ord_q      <= ord_d;
    req_q      <= req_d;
    found_q    <= found_d;
    res_page_q <= res_page_d;
    res_st_q   <= res_st_d;
    opage_q    <= opage_d;
    ost_q      <= ost_d;
    ofree_q    <= ofree_d;
  end
endmodule

### dv/tb_buddy_page_allocator_unit.sv
// Testbench for the buddy page allocator: drives alloc/free words with random
// bursts and stalls, predicts each response with its own buddy table model.
// Depends on bpa_pkg, bpa_req_if, bpa_rsp_if and buddy_page_allocator_unit.

class bpa_scoreboard;
  localparam int PoolLog2 = 12;
  localparam int MaxOrd   = 10;
  localparam int TopOrd   = (MaxOrd < PoolLog2) ? MaxOrd : PoolLog2;
  localparam int Pool     = 1 << PoolLog2;

  bit        hd_valid[Pool];
  bit        hd_free[Pool];
  bit  [3:0] hd_order[Pool];
  int        pages_free;
  int        mismatches;
  // expected response words: {alloc_page, status, free_pages}
  logic [26:0] expected_rsp[$];

  function new();
    for (int p = 0; p < Pool; p++) begin
      hd_valid[p] = (p % (1 << TopOrd)) == 0;
      hd_free[p]  = hd_valid[p];
      hd_order[p] = 4'(TopOrd);
    end
    pages_free = Pool;
    mismatches = 0;
  endfunction

  function bit free_head(int p, int o);
    return hd_valid[p] && hd_free[p] && hd_order[p] == o;
  endfunction

  // Predict one request word and queue the response it causes
  function void note_request(bpa_pkg::bpa_action_e act, logic [3:0] ord,
                             logic [11:0] pg);
    int o;
    int base;
    int found;
    int bud;
    int page;
    bpa_pkg::bpa_status_e st;
    base = 0;
    found = 0;
    st = bpa_pkg::ST_OK;
    if (act == bpa_pkg::ACT_ALLOC) begin
      if (ord > MaxOrd) st = bpa_pkg::ST_BAD_ORDER;
      else begin
        for (o = ord; o <= TopOrd && !found; o++)
          for (int p = 0; p < Pool && !found; p += (1 << o))
            if (free_head(p, o)) begin
              found = 1;
              base = p;
              page = o;
            end
        if (!found) st = bpa_pkg::ST_NO_MEM;
        else begin
          for (o = page; o > ord; o--) begin
            bud = base + (1 << (o - 1));
            hd_valid[bud] = 1;
            hd_free[bud] = 1;
            hd_order[bud] = 4'(o - 1);
          end
          hd_valid[base] = 1;
          hd_free[base] = 0;
          hd_order[base] = ord;
          pages_free -= 1 << ord;
        end
      end
    end else begin
      page = pg;
      if (page >= Pool || !hd_valid[page] || hd_free[page]) st = bpa_pkg::ST_BAD_FREE;
      else begin
        o = hd_order[page];
        if (o > TopOrd) o = TopOrd;
        pages_free += 1 << o;
        // merge upward while the buddy of equal order is free
        while (o < TopOrd) begin
          bud = page ^ (1 << o);
          if (!free_head(bud, o)) break;
          hd_valid[bud > page ? bud : page] = 0;
          hd_free[bud > page ? bud : page] = 0;
          if (bud < page) page = bud;
          o++;
        end
        hd_valid[page] = 1;
        hd_free[page] = 1;
        hd_order[page] = 4'(o);
      end
    end
    expected_rsp.push_back({12'(base), st, 13'(pages_free)});
  endfunction

  function void check_response(logic [11:0] pg, logic [1:0] st, logic [12:0] fp);
    logic [26:0] exp_w;
    if (expected_rsp.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected response word page=%0d", pg);
      return;
    end
    exp_w = expected_rsp.pop_front();
    if (exp_w !== {pg, st, fp}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp page=%0d st=%0d free=%0d, got page=%0d st=%0d free=%0d",
                 exp_w[26:15], exp_w[14:13], exp_w[12:0], pg, st, fp);
    end
  endfunction
endclass

module tb_buddy_page_allocator_unit;
  import bpa_pkg::*;

  // an order-0 alloc probes every page head, before stalls
  localparam int IdleLimit = 60000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   idle_cycles = 0;
  bit   stim_done = 0;
  logic [11:0] owned_pages[$];

  bpa_req_if req_if();
  bpa_rsp_if rsp_if();
  bpa_scoreboard alloc_sb = new();

  buddy_page_allocator_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    req_if.valid = 1'b0;
    req_if.action = 1'b0;
    req_if.req_order = '0;
    req_if.page_index = '0;
    rsp_if.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
  end

  // Note accepted words, check responses, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        alloc_sb.note_request(bpa_action_e'(req_if.action), req_if.req_order,
                              req_if.page_index);
        if (req_if.action == ACT_ALLOC && alloc_sb.expected_rsp[$][14:13] == ST_OK)
          owned_pages.push_back(alloc_sb.expected_rsp[$][26:15]);
      end
      if (rsp_if.valid && rsp_if.ready)
        alloc_sb.check_response(rsp_if.alloc_page, rsp_if.status, rsp_if.free_pages);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver stall pattern: long ready runs mixed with random stalls
  initial begin
    int mode;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(1, 40)) begin
        @(negedge clk_i);
        rsp_if.ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, mode) == 0);
      end
    end
  end

  // Send one word and hold it until accepted
  task automatic send_word(bpa_action_e act, logic [3:0] ord, logic [11:0] pg);
    req_if.valid <= 1'b1;
    req_if.action <= act;
    req_if.req_order <= ord;
    req_if.page_index <= pg;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    @(negedge clk_i);
  endtask

  task automatic gap();
    req_if.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  task automatic free_owned(bit pick_random);
    int k;
    logic [11:0] pg;
    if (owned_pages.size() == 0) begin
      send_word(ACT_FREE, '0, 12'($urandom));
      return;
    end
    k = pick_random ? $urandom_range(0, owned_pages.size() - 1) : 0;
    pg = owned_pages[k];
    owned_pages.delete(k);
    send_word(ACT_FREE, '0, pg);
  endtask

  initial begin
    int burst;
    int r;
    @(posedge rst_ni);
    @(negedge clk_i);
    // Directed: extremes of order, bad orders, double and bad frees, exhaustion
    send_word(ACT_ALLOC, 4'd0, 12'hfff);
    send_word(ACT_ALLOC, 4'd10, '0);
    send_word(ACT_ALLOC, 4'd11, '0);
    send_word(ACT_ALLOC, 4'd15, 12'hfff);
    send_word(ACT_FREE, '0, 12'h001);
    send_word(ACT_FREE, '0, 12'hfff);
    send_word(ACT_FREE, '0, 12'h400);
    for (int i = 0; i < 4; i++) send_word(ACT_ALLOC, 4'd10, '0);
    send_word(ACT_ALLOC, 4'd0, '0);
    send_word(ACT_FREE, '0, 12'h000);
    send_word(ACT_FREE, '0, 12'h000);
    send_word(ACT_FREE, '0, 12'h001);
    // let earlier alloc records settle before using the owned list
    req_if.valid <= 1'b0;
    while (alloc_sb.expected_rsp.size() != 0) @(negedge clk_i);
    while (owned_pages.size() != 0) free_owned(0);
    // Random: mostly valid alloc/free sequences, some noise
    for (int n = 0; n < 450; n += burst) begin
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst; j++) begin
        r = $urandom_range(0, 99);
        if (r < 50)
          send_word(ACT_ALLOC, ($urandom_range(0, 9) == 0) ? 4'($urandom)
                    : 4'($urandom_range(0, 5)), 12'($urandom));
        else if (r < 90) free_owned(1);
        else send_word(ACT_FREE, 4'($urandom), 12'($urandom));
      end
      if ($urandom_range(0, 2) != 0) gap();
    end
    req_if.valid <= 1'b0;
    stim_done = 1;
  end

  // End of run: drain, settle, report
  initial begin
    wait (stim_done);
    while (alloc_sb.expected_rsp.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (alloc_sb.mismatches == 0 && alloc_sb.expected_rsp.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

### sim.f
src/bpa_pkg.sv
src/bpa_req_if.sv
src/bpa_rsp_if.sv
src/bpa_mem.sv
src/buddy_page_allocator_unit.sv
dv/tb_buddy_page_allocator_unit.sv
